// ===== sv/cse_pkg.sv =====
// Shared types and constants for the cosine similarity engine.
`timescale 1ns / 1ps
`default_nettype none
package cse_pkg;
    localparam int ELEM_W    = 16;
    localparam int DOT_W     = 44;
    localparam int SQ_W      = 43;
    localparam int BIG_W     = 128;
    localparam int MUL_W     = 44;
    localparam int MUL_STEPS = 44;
    localparam int CNT_W     = 6;
    localparam int COS_W     = 16;

    localparam logic [COS_W-1:0] COS_ONE  = 16'h7FFF;
    localparam logic [COS_W-1:0] COS_ZERO = 16'h0000;
    localparam logic [15:0]      HI_INIT  = 16'h8000;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [SQ_W-1:0]         sa;
        logic [SQ_W-1:0]         sb;
    } job_t;
endpackage
`default_nettype wire

// ===== sv/cosine_similarity_engine_unit.sv =====
// Top level of the streaming cosine similarity engine.
//  channel | dir | tdata                          | tuser      | tlast
//  s_      | in  | [15:0] elem_a, [31:16] elem_b  | -          | last_pair
//  m_      | out | [15:0] cosine                  | degenerate | -
// The front end takes one pair per cycle; s_tready falls only when two
// finished vectors wait in the job queue. The back end pops a job, runs two
// 44-step shift-add multiplies, then up to 16 bisection steps, each a further
// 44-step multiply, and then loads the output register. A degenerate vector
// pair skips the multiplies and the bisection.
// aresetn is synchronous, active low; it empties the queue and accumulators.
`timescale 1ns / 1ps
`default_nettype none
module cosine_similarity_engine_unit import cse_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // elem_a, elem_b
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // cosine
    output logic [0:0]       m_tuser    // degenerate
);
    job_t push_job, pop_job;
    logic push, pop, full, job_valid, accept, deg;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    assign m_tuser  = deg;

    cse_front u_front (
        .aclk(aclk), .aresetn(aresetn), .accept(accept),
        .elem_a(s_tdata[15:0]), .elem_b(s_tdata[31:16]), .last_pair(s_tlast),
        .push(push), .job(push_job)
    );

    cse_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_job(push_job),
        .full(full), .ready_out(job_valid), .pop(pop), .pop_job(pop_job)
    );

    cse_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(job_valid), .job(pop_job),
        .pop(pop), .m_valid(m_tvalid), .m_ready(m_tready),
        .cosine(m_tdata), .degenerate(deg)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("job pushed into full queue");
    a_degen_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && deg |-> (m_tdata == COS_ONE || m_tdata == COS_ZERO))
        else $error("degenerate result with unexpected cosine");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> job_valid) else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

// ===== sv/cse_front.sv =====
// Front end: accumulates dot product and sums of squares, emits one job per vector.
`timescale 1ns / 1ps
`default_nettype none
module cse_front import cse_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     accept,
    input  wire logic signed [ELEM_W-1:0] elem_a,
    input  wire logic signed [ELEM_W-1:0] elem_b,
    input  wire logic                     last_pair,
    output logic                          push,
    output job_t                          job
);
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [SQ_W-1:0]         sa_reg, sa_next, sb_reg, sb_next;
    logic signed [31:0]      prod, qa, qb;
    logic signed [DOT_W:0]   dsum;
    logic [SQ_W:0]           asum, bsum;

    always_comb begin
        prod = elem_a * elem_b;
        qa   = elem_a * elem_a;
        qb   = elem_b * elem_b;
        dsum = {{(DOT_W+1-32){prod[31]}}, prod} + {dot_reg[DOT_W-1], dot_reg};
        asum = {1'b0, sa_reg} + (SQ_W+1)'(qa[30:0]);
        bsum = {1'b0, sb_reg} + (SQ_W+1)'(qb[30:0]);
        // clamp at the accumulator widths
        if (dsum[DOT_W:DOT_W-1] == 2'b01) begin
            dot_next = {1'b0, {(DOT_W-1){1'b1}}};
        end else if (dsum[DOT_W:DOT_W-1] == 2'b10) begin
            dot_next = {1'b1, {(DOT_W-1){1'b0}}};
        end else begin
            dot_next = dsum[DOT_W-1:0];
        end
        sa_next  = asum[SQ_W] ? {SQ_W{1'b1}} : asum[SQ_W-1:0];
        sb_next  = bsum[SQ_W] ? {SQ_W{1'b1}} : bsum[SQ_W-1:0];
        job.dot  = dot_next;
        job.sa   = sa_next;
        job.sb   = sb_next;
        push     = accept && last_pair;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            dot_reg <= '0;
            sa_reg  <= '0;
            sb_reg  <= '0;
        end else if (accept) begin
            dot_reg <= dot_next;
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/cse_queue.sv =====
// Two-entry job queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module cse_queue import cse_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_job,
    output logic      full,
    output logic      ready_out,
    input  wire logic pop,
    output job_t      pop_job
);
    job_t       slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign ready_out = cnt_reg != 2'd0;
    assign pop_job   = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== sv/cse_back.sv =====
// Back end: serial shift-add multiplier and bisection search for the cosine.
`timescale 1ns / 1ps
`default_nettype none
module cse_back import cse_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        job_valid,
    input  job_t             job,
    output logic             pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [COS_W-1:0] cosine,
    output logic             degenerate
);
    typedef enum logic [2:0] {S_IDLE, S_MP, S_MR, S_MID, S_ML, S_OUT} state_t;

    state_t           state_reg;
    logic [BIG_W-1:0] mc_reg, acc_reg, p_reg, r_reg;
    logic [MUL_W-1:0] mp_reg, adot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      lo_reg, hi_reg, mid_reg;
    logic             neg_reg;
    logic [COS_W-1:0] res_reg, cos_reg;
    logic             rdeg_reg, deg_reg, mval_reg;

    logic [BIG_W-1:0] acc_next;
    logic [16:0]      msum, tval;
    logic [15:0]      mid;
    logic [33:0]      tsq;
    logic [MUL_W-1:0] jabs;
    logic             mul_last, out_free;

    always_comb begin
        acc_next = mp_reg[0] ? acc_reg + mc_reg : acc_reg;
        mul_last = cnt_reg == CNT_W'(1);
        msum     = {1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1;
        mid      = msum[16:1];
        tval     = {mid, 1'b0} - 17'd1;
        tsq      = tval * tval;
        jabs     = job.dot[DOT_W-1] ? MUL_W'(-job.dot) : MUL_W'(job.dot);
        out_free = !mval_reg || m_ready;
        pop      = state_reg == S_IDLE && job_valid;
    end

    assign m_valid    = mval_reg;
    assign cosine     = cos_reg;
    assign degenerate = deg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            if (m_ready && state_reg != S_OUT) mval_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        adot_reg <= jabs;
                        neg_reg  <= job.dot[DOT_W-1];
                        if (job.sa == '0 || job.sb == '0) begin
                            rdeg_reg  <= 1'b1;
                            res_reg   <= (job.sa == '0 && job.sb == '0) ? COS_ONE : COS_ZERO;
                            state_reg <= S_OUT;
                        end else begin
                            rdeg_reg  <= 1'b0;
                            mc_reg    <= BIG_W'(job.sa);
                            mp_reg    <= MUL_W'(job.sb);
                            acc_reg   <= '0;
                            cnt_reg   <= CNT_W'(MUL_STEPS);
                            state_reg <= S_MP;
                        end
                    end
                end
                S_MP, S_MR, S_ML: begin
                    if (mul_last) begin
                        if (state_reg == S_MP) begin
                            p_reg     <= acc_next;
                            mc_reg    <= BIG_W'(adot_reg);
                            mp_reg    <= adot_reg;
                            acc_reg   <= '0;
                            cnt_reg   <= CNT_W'(MUL_STEPS);
                            state_reg <= S_MR;
                        end else if (state_reg == S_MR) begin
                            r_reg     <= acc_next << 32;
                            lo_reg    <= '0;
                            hi_reg    <= HI_INIT;
                            state_reg <= S_MID;
                        end else begin
                            // keep mid when the scaled denominator fits under the numerator
                            if (acc_next <= r_reg) lo_reg <= mid_reg;
                            else                   hi_reg <= mid_reg - 16'd1;
                            state_reg <= S_MID;
                        end
                    end else begin
                        acc_reg <= acc_next;
                        mc_reg  <= mc_reg << 1;
                        mp_reg  <= mp_reg >> 1;
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                S_MID: begin
                    if (lo_reg >= hi_reg) begin
                        if (neg_reg)        res_reg <= -lo_reg;
                        else if (lo_reg[15]) res_reg <= COS_ONE;
                        else                res_reg <= lo_reg;
                        state_reg <= S_OUT;
                    end else begin
                        mid_reg   <= mid;
                        mc_reg    <= p_reg;
                        mp_reg    <= MUL_W'(tsq[31:0]);
                        acc_reg   <= '0;
                        cnt_reg   <= CNT_W'(MUL_STEPS);
                        state_reg <= S_ML;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        cos_reg   <= res_reg;
                        deg_reg   <= rdeg_reg;
                        mval_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the streaming cosine similarity engine.
`timescale 1ns / 1ps
module testbench;
    import cse_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 1000;
    localparam longint DOT_HI     = (64'sd1 <<< 43) - 1;
    localparam longint DOT_LO     = -(64'sd1 <<< 43);
    localparam longint unsigned SQ_HI = (64'd1 << 43) - 1;

    typedef struct {
        logic signed [15:0] cosine;
        logic               degenerate;
    } cos_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // elem_a [15:0], elem_b [31:16]
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // cosine
    logic [0:0]  m_tuser;        // degenerate

    cosine_similarity_engine_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Running accumulators of the predictor and the results still owed
    longint             dot_sum;
    longint unsigned    sq_sum_a, sq_sum_b;
    cos_result_t        pending_cos[$];
    int                 fail_count = 0;
    int                 vectors_done = 0;
    int                 pairs_sent = 0;
    bit                 sender_idles = 1'b1;
    bit                 sink_idles = 1'b1;
    int                 sink_hold = 0;
    int                 quiet_cycles = 0;

    function automatic cos_result_t predict_cosine(longint dot, longint unsigned sa,
                                                   longint unsigned sb);
        cos_result_t r;
        logic [127:0] rhs, lhs, adot, t;
        int lo, hi, mid;
        if (sa == 0 || sb == 0) begin
            r.degenerate = 1'b1;
            r.cosine = (sa == 0 && sb == 0) ? COS_ONE : COS_ZERO;
            return r;
        end
        adot = (dot < 0) ? 128'(-dot) : 128'(dot);
        rhs = (adot * adot) << 32;
        lo = 0;
        hi = 32768;
        // bisect for the largest m with (2m-1)^2 * sa * sb <= 4 * dot^2 * 2^30
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 128'(2 * mid - 1);
            lhs = t * t * 128'(sa) * 128'(sb);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        r.degenerate = 1'b0;
        if (dot < 0) r.cosine = 16'(-lo);
        else r.cosine = (lo > 32767) ? COS_ONE : 16'(lo);
        return r;
    endfunction

    function automatic void accumulate_pair(logic signed [15:0] a, logic signed [15:0] b,
                                            bit last);
        longint d;
        longint unsigned qa, qb;
        d = dot_sum + longint'(a) * longint'(b);
        qa = longint'(a) * longint'(a);
        qb = longint'(b) * longint'(b);
        dot_sum = (d > DOT_HI) ? DOT_HI : ((d < DOT_LO) ? DOT_LO : d);
        sq_sum_a = (qa > SQ_HI - sq_sum_a) ? SQ_HI : sq_sum_a + qa;
        sq_sum_b = (qb > SQ_HI - sq_sum_b) ? SQ_HI : sq_sum_b + qb;
        if (last) begin
            pending_cos.insert(pending_cos.size(), predict_cosine(dot_sum, sq_sum_a, sq_sum_b));
            dot_sum = 0;
            sq_sum_a = 0;
            sq_sum_b = 0;
        end
    endfunction

    task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, bit last);
        while (sender_idles && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        accumulate_pair(a, b, last);
        pairs_sent++;
    endtask

    task automatic send_random_vector(int len);
        logic signed [15:0] a, b;
        int mode;
        mode = int'($urandom_range(9));
        for (int i = 0; i < len; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            // mix in zero vectors, parallel, anti-parallel and small-valued pairs
            case (mode)
                0: a = 0;
                1: b = 0;
                2: b = a;
                3: b = (a == -32768) ? 16'sd32767 : -a;
                4: begin a = 16'($urandom_range(15)); b = 16'($urandom_range(15)); end
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_cos.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_pair(16'sd0, 16'sd0, 1'b1);            // both vectors zero
        send_pair(16'sd0, 16'sd1234, 1'b1);         // first zero
        send_pair(-16'sd5, 16'sd0, 1'b1);           // second zero
        send_pair(16'sd0, 16'sd0, 1'b0);
        send_pair(16'sd0, -16'sd32768, 1'b1);
        send_pair(16'sd32767, 16'sd32767, 1'b1);    // exactly +1.0
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(16'sd32767, -16'sd32767, 1'b1);   // exactly -1.0
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(16'sd1, 16'sd0, 1'b0);            // orthogonal
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(-16'sd4, 16'sd3, 1'b0);
        send_pair(16'sd100, -16'sd7, 1'b1);
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b1);           // orthogonal, dot product zero
        drain_results();
    endtask

    task automatic test_full_scale();
        sender_idles = 1'b0;
        for (int i = 0; i < 40; i++) send_pair(-16'sd32768, -16'sd32768, i == 39);
        for (int i = 0; i < 40; i++) send_pair(-16'sd32768, 16'sd32767, i == 39);
        sender_idles = 1'b1;
        drain_results();
    endtask

    task automatic test_random_short();
        int start;
        start = pairs_sent;
        while (pairs_sent - start < 900)
            send_random_vector(($urandom_range(9) == 0) ? $urandom_range(64)+1
                                                         : $urandom_range(8)+1);
        drain_results();
    endtask

    task automatic test_backpressure();
        sink_hold = 4000;
        for (int i = 0; i < 20; i++) send_random_vector($urandom_range(3) + 1);
        drain_results();
    endtask

    task automatic test_no_idle();
        int start;
        start = pairs_sent;
        sender_idles = 1'b0;
        sink_idles = 1'b0;
        while (pairs_sent - start < 600) send_random_vector($urandom_range(10) + 1);
        sender_idles = 1'b1;
        sink_idles = 1'b1;
        drain_results();
    endtask

    // Receiver: random stalls while sink_idles is set, with a long hold-off on request
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !sink_idles || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cos.size() == 0) begin
                $error("result with none expected: cosine %0d degenerate %0d",
                       $signed(m_tdata), m_tuser);
                fail_count++;
            end else begin
                cos_result_t e;
                e = pending_cos.pop_front();
                if (m_tdata !== e.cosine) begin
                    $error("cosine: expected %0d, actual %0d", e.cosine, $signed(m_tdata));
                    fail_count++;
                end
                if (m_tuser[0] !== e.degenerate) begin
                    $error("degenerate: expected %0d, actual %0d", e.degenerate, m_tuser);
                    fail_count++;
                end
                vectors_done++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        dot_sum = 0;
        sq_sum_a = 0;
        sq_sum_b = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_short();
        test_backpressure();
        test_no_idle();
        test_full_scale();
        s_tvalid <= 1'b0;
        while (pending_cos.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_cos.size() != 0) begin
            $error("%0d results never arrived", pending_cos.size());
            fail_count++;
        end
        $display("Covered %0d element pairs in %0d vectors: zero, parallel, full-scale",
                 pairs_sent, vectors_done);
        $display("and random vectors under random and long output stalls.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
